@@ sv/hce_pkg.sv @@
// hce_pkg: constants, types and helper functions for the hill cipher encryptor
// used by hill_cipher_encrypt_top; depends on nothing else
`default_nettype none

package hce_pkg;

   localparam int unsigned CHAR_W    = 8;   // message byte
   localparam int unsigned OUT_W     = 7;   // upper-case ascii out
   localparam int unsigned LET_W     = 5;   // letter value 1..26, key entry 0..31
   localparam int unsigned KEY_W     = 15;  // three key entries per row
   localparam int unsigned SUM_W     = 12;  // three 5x5-bit products
   localparam int unsigned MAX_BLK   = 3;   // largest block size
   localparam int unsigned FIFO_DEPTH = 4;  // queued blocks
   localparam int unsigned PTR_W     = $clog2(FIFO_DEPTH);
   localparam int unsigned FCNT_W    = $clog2(FIFO_DEPTH + 2);

   localparam int unsigned LETTERS   = 26;
   localparam int unsigned LETTER_BASE = 64;
   localparam int unsigned CASE_GAP  = 32;
   localparam int unsigned LOWER_A   = 97;
   localparam int unsigned LOWER_Z   = 122;
   localparam int unsigned UPPER_A   = 65;
   localparam int unsigned UPPER_Z   = 90;
   localparam int unsigned PAD_VALUE = 26;
   // floor(2^15 / 26): quotient estimate is exact or one low for sums below 4096
   localparam int unsigned RECIP     = 1260;
   localparam int unsigned RECIP_SH  = 15;
   localparam int unsigned PROD_W    = SUM_W + 11;

   typedef enum logic [1:0] {
      CSR_BLOCK_SIZE = 2'd0,
      CSR_KEY_ROW0   = 2'd1,
      CSR_KEY_ROW1   = 2'd2,
      CSR_KEY_ROW2   = 2'd3
   } csr_index_type;

   // one encrypted block waiting for the result channel
   typedef struct packed {
      logic [MAX_BLK-1:0][OUT_W-1:0] chars;
      logic                          size3;
      logic                          at_end;
   } block_type;

   function automatic logic [LET_W-1:0] mod26(input logic [SUM_W-1:0] x);
      logic [PROD_W-1:0] prod;
      logic [SUM_W-1:0]  quot;
      logic [SUM_W-1:0]  rem;
      prod = PROD_W'(x) * PROD_W'(RECIP);
      quot = SUM_W'(prod >> RECIP_SH);
      rem  = x - SUM_W'(quot * SUM_W'(LETTERS));
      if (rem >= SUM_W'(LETTERS)) begin
         rem = rem - SUM_W'(LETTERS);
      end
      return rem[LET_W-1:0];
   endfunction

   // zero stands for 'Z', any other value v for 'A'+v-1
   function automatic logic [OUT_W-1:0] to_ascii(input logic [LET_W-1:0] r);
      logic [OUT_W-1:0] c;
      if (r == '0) begin
         c = OUT_W'(UPPER_Z);
      end else begin
         c = OUT_W'(LETTER_BASE) + OUT_W'(r);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/hill_cipher_encrypt_top.sv @@
// hill_cipher_encrypt_top: streaming hill cipher encryption mod 26, 2x2 or 3x3 key
// depends on hce_pkg (constants, block type, mod 26 and ascii helpers)
//
//   channel   ports                                   direction
//   req       req_valid/ready, char_in, end_of_message  in
//   rsp       rsp_valid/ready, cipher_char, last_*      out
//   csr       csr_we, csr_index, csr_wdata              in, write only
//
// one message byte is taken per cycle while req_ready is high; a completed block is registered,
// multiplied by the key in the next cycle and written to a four-block queue, whose head block
// gives one letter per cycle while rsp_ready is high.
// req_ready drops only when the queue plus the block in flight fill all four slots.
// reset is synchronous; it clears the counts, empties the queue, clears the key and sets block size 2.
`default_nettype none

module hill_cipher_encrypt_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [hce_pkg::CHAR_W-1:0]    req_char_in,
   input  wire logic                          req_end_of_message,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [hce_pkg::OUT_W-1:0]          rsp_cipher_char,
   output logic                               rsp_last_of_block,
   output logic                               rsp_last_of_message,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [hce_pkg::KEY_W-1:0]     csr_wdata
);

   // configuration
   logic [1:0]                                    block_size_ff;
   logic [hce_pkg::MAX_BLK-1:0][hce_pkg::KEY_W-1:0] key_ff;

   // gathering stage
   logic [hce_pkg::MAX_BLK-1:0][hce_pkg::LET_W-1:0] pend_ff, pend_in;
   logic [1:0]                                    pend_cnt_ff, pend_cnt_in;
   logic [hce_pkg::CHAR_W-1:0]                    up_char;
   logic                                          is_letter;
   logic                                          size3;
   logic [2:0]                                    blk_len;
   logic [2:0]                                    cnt_new;
   logic                                          emit;
   logic                                          req_accept;
   logic [hce_pkg::MAX_BLK-1:0][hce_pkg::LET_W-1:0] blk_m;

   // block in flight to the multiplier
   logic                                          emit_valid_ff;
   logic [hce_pkg::MAX_BLK-1:0][hce_pkg::LET_W-1:0] emit_m_ff;
   logic                                          emit_size3_ff;
   logic                                          emit_end_ff;

   // multiply stage
   logic [hce_pkg::MAX_BLK-1:0][hce_pkg::SUM_W-1:0] row_sum;
   hce_pkg::block_type                            blk_in;

   // block queue and letter read-out
   hce_pkg::block_type                            fifo_mem [hce_pkg::FIFO_DEPTH];
   logic [hce_pkg::PTR_W-1:0]                     wr_ptr_ff;
   logic [hce_pkg::PTR_W-1:0]                     rd_ptr_ff;
   logic [hce_pkg::FCNT_W-1:0]                    fifo_cnt_ff;
   logic [hce_pkg::FCNT_W-1:0]                    occupancy;
   logic [1:0]                                    out_idx_ff;
   hce_pkg::block_type                            head;
   logic                                          last_letter;
   logic                                          pop;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= 2'd2;
         key_ff        <= '0;
      end else if (csr_we) begin
         unique case (hce_pkg::csr_index_type'(csr_index))
            hce_pkg::CSR_BLOCK_SIZE: block_size_ff <= csr_wdata[1:0];
            hce_pkg::CSR_KEY_ROW0:   key_ff[0]     <= csr_wdata;
            hce_pkg::CSR_KEY_ROW1:   key_ff[1]     <= csr_wdata;
            hce_pkg::CSR_KEY_ROW2:   key_ff[2]     <= csr_wdata;
            default:                 block_size_ff <= block_size_ff;
         endcase
      end
   end

   // letter decode and block gathering
   always_comb begin
      if (req_char_in >= hce_pkg::CHAR_W'(hce_pkg::LOWER_A) &&
          req_char_in <= hce_pkg::CHAR_W'(hce_pkg::LOWER_Z)) begin
         up_char = req_char_in - hce_pkg::CHAR_W'(hce_pkg::CASE_GAP);
      end else begin
         up_char = req_char_in;
      end
      is_letter = (up_char >= hce_pkg::CHAR_W'(hce_pkg::UPPER_A)) &&
                  (up_char <= hce_pkg::CHAR_W'(hce_pkg::UPPER_Z));
      size3   = (block_size_ff == 2'd3);
      blk_len = size3 ? 3'd3 : 3'd2;
      cnt_new = {1'b0, pend_cnt_ff} + {2'b00, is_letter};

      for (int i = 0; i < hce_pkg::MAX_BLK; i++) begin
         // ascii 'A'..'Z' carry their value 1..26 in the low five bits
         if (is_letter && pend_cnt_ff == 2'(i)) begin
            pend_in[i] = up_char[hce_pkg::LET_W-1:0];
         end else begin
            pend_in[i] = pend_ff[i];
         end
         // letters beyond the count are padding
         if (3'(i) < cnt_new) begin
            blk_m[i] = pend_in[i];
         end else begin
            blk_m[i] = hce_pkg::LET_W'(hce_pkg::PAD_VALUE);
         end
      end

      emit = (is_letter && cnt_new >= blk_len) ||
             (req_end_of_message && cnt_new != 3'd0);
      pend_cnt_in = emit ? 2'd0 : cnt_new[1:0];
   end

   assign occupancy  = hce_pkg::FCNT_W'(fifo_cnt_ff) + hce_pkg::FCNT_W'(emit_valid_ff);
   assign req_ready  = occupancy < hce_pkg::FCNT_W'(hce_pkg::FIFO_DEPTH);
   assign req_accept = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff   <= 2'd0;
         emit_valid_ff <= 1'b0;
      end else begin
         emit_valid_ff <= req_accept & emit;
         if (req_accept) begin
            pend_cnt_ff <= pend_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_ff       <= pend_in;
         emit_m_ff     <= blk_m;
         emit_size3_ff <= size3;
         emit_end_ff   <= req_end_of_message;
      end
   end

   // key times block, mod 26
   always_comb begin
      for (int i = 0; i < hce_pkg::MAX_BLK; i++) begin
         row_sum[i] = '0;
         for (int j = 0; j < hce_pkg::MAX_BLK; j++) begin
            if (j < 2 || emit_size3_ff) begin
               row_sum[i] = row_sum[i] +
                  hce_pkg::SUM_W'(key_ff[i][hce_pkg::LET_W*j +: hce_pkg::LET_W]) *
                  hce_pkg::SUM_W'(emit_m_ff[j]);
            end
         end
         blk_in.chars[i] = hce_pkg::to_ascii(hce_pkg::mod26(row_sum[i]));
      end
      blk_in.size3  = emit_size3_ff;
      blk_in.at_end = emit_end_ff;
   end

   always_ff @(posedge clock) begin
      if (emit_valid_ff) begin
         fifo_mem[wr_ptr_ff] <= blk_in;
      end
   end

   // result channel, one letter of the head block per transaction
   assign head        = fifo_mem[rd_ptr_ff];
   assign rsp_valid   = (fifo_cnt_ff != '0);
   assign last_letter = (out_idx_ff == (head.size3 ? 2'd2 : 2'd1));
   assign pop         = rsp_valid & rsp_ready & last_letter;

   assign rsp_cipher_char     = head.chars[out_idx_ff];
   assign rsp_last_of_block   = last_letter;
   assign rsp_last_of_message = last_letter & head.at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         out_idx_ff  <= 2'd0;
      end else begin
         if (emit_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + hce_pkg::PTR_W'(1);
         end
         if (rsp_valid && rsp_ready) begin
            if (last_letter) begin
               out_idx_ff <= 2'd0;
               rd_ptr_ff  <= rd_ptr_ff + hce_pkg::PTR_W'(1);
            end else begin
               out_idx_ff <= out_idx_ff + 2'd1;
            end
         end
         fifo_cnt_ff <= fifo_cnt_ff + hce_pkg::FCNT_W'(emit_valid_ff)
                                    - hce_pkg::FCNT_W'(pop);
      end
   end

endmodule

`default_nettype wire
